### hdl/websocket_frame_unmasker_top_defines.svh
// Assertion helpers for the frame unmasker top.
// Both expect a clock named clk and an active-high reset named rst in scope.
`ifndef WEBSOCKET_FRAME_UNMASKER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASKER_TOP_DEFINES_SVH

// Same-cycle implication.
`define WSFU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WSFU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/wsfu_pkg.sv
package wsfu_pkg;

  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_EXTLEN  = 2'd2
  } status_t;

  // Length codes at or above this value announce an extended length field.
  localparam logic [6:0] LEN_EXT_MIN = 7'd126;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] opcode;
    logic       final_flag;
    logic [2:0] reserved_bits;
    logic       mask_present;
    logic [6:0] frame_length;
    logic       last_of_frame;
    status_t    status;
  } result_t;

endpackage

### hdl/wsfu_parse.sv
module wsfu_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        frame_byte,
  output logic              emit,
  output wsfu_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_KEY0 = 3'd2,
    PH_KEY1 = 3'd3,
    PH_KEY2 = 3'd4,
    PH_KEY3 = 3'd5,
    PH_DATA = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] mask_key, mask_key_next;
  logic [6:0]  bytes_left, bytes_left_next;
  logic [1:0]  key_index, key_index_next;
  logic [3:0]  held_opcode, held_opcode_next;
  logic        held_fin, held_fin_next;
  logic [2:0]  held_reserved, held_reserved_next;
  logic        held_mask_bit, held_mask_bit_next;
  logic [6:0]  held_length, held_length_next;
  logic [7:0]  key_byte;

  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[7:0];
      2'd1:    key_byte = mask_key[15:8];
      2'd2:    key_byte = mask_key[23:16];
      default: key_byte = mask_key[31:24];
    endcase
  end

  always_comb begin
    phase_next         = phase;
    mask_key_next      = mask_key;
    bytes_left_next    = bytes_left;
    key_index_next     = key_index;
    held_opcode_next   = held_opcode;
    held_fin_next      = held_fin;
    held_reserved_next = held_reserved;
    held_mask_bit_next = held_mask_bit;
    held_length_next   = held_length;
    emit               = 1'b0;

    res.payload_byte  = 8'd0;
    res.opcode        = held_opcode;
    res.final_flag    = held_fin;
    res.reserved_bits = held_reserved;
    res.mask_present  = held_mask_bit;
    res.frame_length  = held_length;
    res.last_of_frame = 1'b1;
    res.status        = wsfu_pkg::ST_PAYLOAD;

    unique case (phase)
      PH_HDR1: begin
        held_mask_bit_next = frame_byte[7];
        held_length_next   = frame_byte[6:0];
        res.mask_present   = frame_byte[7];
        res.frame_length   = frame_byte[6:0];
        if (frame_byte[6:0] >= wsfu_pkg::LEN_EXT_MIN) begin
          // Drop the frame: report once and wait for a new header.
          emit        = 1'b1;
          res.status  = wsfu_pkg::ST_EXTLEN;
          phase_next  = PH_HDR0;
        end else begin
          phase_next = PH_KEY0;
        end
      end
      PH_KEY0, PH_KEY1, PH_KEY2: begin
        mask_key_next = {frame_byte, mask_key[31:8]};
        phase_next    = phase_t'(phase + 3'd1);
      end
      PH_KEY3: begin
        mask_key_next = {frame_byte, mask_key[31:8]};
        if (held_length == 7'd0) begin
          emit       = 1'b1;
          res.status = wsfu_pkg::ST_EMPTY;
          phase_next = PH_HDR0;
        end else begin
          bytes_left_next = held_length;
          key_index_next  = 2'd0;
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        emit              = 1'b1;
        res.payload_byte  = frame_byte ^ key_byte;
        res.last_of_frame = (bytes_left == 7'd1);
        key_index_next    = key_index + 2'd1;
        bytes_left_next   = bytes_left - 7'd1;
        if (bytes_left == 7'd1) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        held_fin_next      = frame_byte[7];
        held_reserved_next = frame_byte[6:4];
        held_opcode_next   = frame_byte[3:0];
        phase_next         = PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      mask_key      <= 32'd0;
      bytes_left    <= 7'd0;
      key_index     <= 2'd0;
      held_opcode   <= 4'd0;
      held_fin      <= 1'b0;
      held_reserved <= 3'd0;
      held_mask_bit <= 1'b0;
      held_length   <= 7'd0;
    end else if (step) begin
      phase         <= phase_next;
      mask_key      <= mask_key_next;
      bytes_left    <= bytes_left_next;
      key_index     <= key_index_next;
      held_opcode   <= held_opcode_next;
      held_fin      <= held_fin_next;
      held_reserved <= held_reserved_next;
      held_mask_bit <= held_mask_bit_next;
      held_length   <= held_length_next;
    end
  end

endmodule

### hdl/websocket_frame_unmasker_top.sv
// WebSocket client frame unmasker.
// Input channel: one raw frame byte per word on frame_byte, in_valid/in_ready.
// Output channel: one result word per payload byte, plus one status word for
// an empty frame or for an unsupported extended length code (126, 127),
// out_valid/out_ready. Header bytes and mask-key bytes give no word.
// Each result carries the frame's opcode, FIN, reserved bits, mask bit and
// 7-bit length code; last_of_frame marks the final word of the frame.
// An accepted byte waits in the input register, passes the parse stage and
// has its result registered in the output register, which drives out_valid.
// Throughput: one byte per clock while no receiver stall holds the flow, set
// by the single parse stage between the input register and the output
// register.
// Reset (rst, synchronous): both registers empty, parser waits for a first
// header byte, stored key and header fields cleared.
// Receiver stall: a waiting result holds in the output register; one more
// byte is taken into the input register, and bytes that give no result keep
// flowing; in_ready drops only when a result-producing byte is blocked.
`include "websocket_frame_unmasker_top_defines.svh"

module websocket_frame_unmasker_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] frame_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic [3:0] opcode,
  output logic       final_flag,
  output logic [2:0] reserved_bits,
  output logic       mask_present,
  output logic [6:0] frame_length,
  output logic       last_of_frame,
  output logic [1:0] status
);

  logic              a_valid;
  logic [7:0]        a_byte;
  logic              res_emit;
  logic              b_adv;
  wsfu_pkg::result_t res;
  wsfu_pkg::result_t res_q;
  logic              ext_word_ok;
  logic              empty_word_ok;

  // Advance the parse stage unless it would overwrite a waiting result.
  assign b_adv    = a_valid && (!res_emit || !out_valid || out_ready);
  assign in_ready = !a_valid || b_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_byte <= frame_byte;
    end
  end

  wsfu_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (b_adv),
    .frame_byte (a_byte),
    .emit       (res_emit),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv && res_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (b_adv && res_emit) begin
      res_q <= res;
    end
  end

  assign payload_byte  = res_q.payload_byte;
  assign opcode        = res_q.opcode;
  assign final_flag    = res_q.final_flag;
  assign reserved_bits = res_q.reserved_bits;
  assign mask_present  = res_q.mask_present;
  assign frame_length  = res_q.frame_length;
  assign last_of_frame = res_q.last_of_frame;
  assign status        = res_q.status;

  assign ext_word_ok   = (status != wsfu_pkg::ST_EXTLEN) ||
                         (last_of_frame && payload_byte == 8'd0 &&
                          frame_length >= wsfu_pkg::LEN_EXT_MIN);
  assign empty_word_ok = (status != wsfu_pkg::ST_EMPTY) ||
                         (last_of_frame && frame_length == 7'd0);

  `WSFU_ASSERT_NXT(a_hold_blocked, a_valid && !b_adv, a_valid && $stable(a_byte), "byte lost")
  `WSFU_ASSERT_IMP(a_ready_only_full, !in_ready, a_valid && res_emit && out_valid, "bad in_ready")
  `WSFU_ASSERT_IMP(a_extlen_word, out_valid, ext_word_ok, "bad ext word")
  `WSFU_ASSERT_IMP(a_empty_word, out_valid, empty_word_ok, "bad empty word")

endmodule

### verif/websocket_frame_unmasker_top_tb.sv
module websocket_frame_unmasker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int RANDOM_ITEMS    = 930;
  localparam int QUIET_AFTER     = 800;
  localparam int STALL_LIMIT     = 3000;
  localparam int MAX_REPORTS     = 10;

  typedef enum logic [2:0] {
    P_FIRST   = 3'd0,
    P_SECOND  = 3'd1,
    P_KEY0    = 3'd2,
    P_KEY1    = 3'd3,
    P_KEY2    = 3'd4,
    P_KEY3    = 3'd5,
    P_PAYLOAD = 3'd6
  } parse_phase_t;

  typedef struct {
    logic [7:0]        stim;
    bit                fixed;
    wsfu_pkg::result_t word;
  } frame_row_t;

  localparam wsfu_pkg::result_t NO_WORD = '0;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] frame_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] payload_byte;
  logic [3:0] opcode;
  logic       final_flag;
  logic [2:0] reserved_bits;
  logic       mask_present;
  logic [6:0] frame_length;
  logic       last_of_frame;
  logic [1:0] status;

  // Frame bytes in order; expected words typed in only for the status-word cases.
  frame_row_t frame_rows [0:20] = '{
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hFF, 1'b1, '{8'h00, 4'hF, 1'b1, 3'h7, 1'b1, 7'd127, 1'b1, wsfu_pkg::ST_EXTLEN}},
    '{8'h00, 1'b0, NO_WORD},
    '{8'h7E, 1'b1, '{8'h00, 4'h0, 1'b0, 3'h0, 1'b0, 7'd126, 1'b1, wsfu_pkg::ST_EXTLEN}},
    '{8'h89, 1'b0, NO_WORD},
    '{8'h80, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'hA5, 1'b0, NO_WORD},
    '{8'h5A, 1'b1, '{8'h00, 4'h9, 1'b1, 3'h0, 1'b1, 7'd0, 1'b1, wsfu_pkg::ST_EMPTY}},
    '{8'h01, 1'b0, NO_WORD},
    '{8'h05, 1'b0, NO_WORD},
    '{8'h12, 1'b0, NO_WORD},
    '{8'h34, 1'b0, NO_WORD},
    '{8'h56, 1'b0, NO_WORD},
    '{8'h78, 1'b0, NO_WORD},
    '{8'h00, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, NO_WORD},
    '{8'h80, 1'b0, NO_WORD},
    '{8'h7F, 1'b0, NO_WORD},
    '{8'hAA, 1'b0, NO_WORD}
  };

  // Parser copy kept alongside the block
  parse_phase_t parse_phase = P_FIRST;
  logic [31:0]  key_word    = '0;
  logic [6:0]   bytes_due   = '0;
  logic [1:0]   key_sel     = '0;
  logic [3:0]   hdr_opcode  = '0;
  logic         hdr_fin     = 1'b0;
  logic [2:0]   hdr_rsv     = '0;
  logic         hdr_mask    = 1'b0;
  logic [6:0]   hdr_len     = '0;

  frame_row_t        offered_rows [$];
  wsfu_pkg::result_t expected_words [$];
  int                mismatches    = 0;
  int                items_offered = 0;
  int                idle_cycles   = 0;
  bit                quiet         = 1'b0;
  bit                gaps_on       = 1'b1;
  bit                stalls_on     = 1'b1;
  bit                held_off      = 1'b0;

  websocket_frame_unmasker_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .frame_byte    (frame_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .opcode        (opcode),
    .final_flag    (final_flag),
    .reserved_bits (reserved_bits),
    .mask_present  (mask_present),
    .frame_length  (frame_length),
    .last_of_frame (last_of_frame),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic wsfu_pkg::result_t frame_word(logic [7:0] data, logic last,
                                                   wsfu_pkg::status_t st);
    return '{data, hdr_opcode, hdr_fin, hdr_rsv, hdr_mask, hdr_len, last, st};
  endfunction

  task automatic unmask_byte(input logic [7:0] b, output bit produced,
                             output wsfu_pkg::result_t w);
    logic [7:0] k;
    produced = 1'b0;
    w = NO_WORD;
    case (parse_phase)
      P_SECOND: begin
        hdr_mask = b[7];
        hdr_len  = b[6:0];
        if (hdr_len >= wsfu_pkg::LEN_EXT_MIN) begin
          produced = 1'b1;
          w = frame_word(8'h00, 1'b1, wsfu_pkg::ST_EXTLEN);
          parse_phase = P_FIRST;
        end else begin
          parse_phase = P_KEY0;
        end
      end
      P_KEY0, P_KEY1, P_KEY2, P_KEY3: begin
        key_word = {b, key_word[31:8]};
        if (parse_phase != P_KEY3) begin
          parse_phase = parse_phase_t'(parse_phase + 3'd1);
        end else if (hdr_len == 7'd0) begin
          produced = 1'b1;
          w = frame_word(8'h00, 1'b1, wsfu_pkg::ST_EMPTY);
          parse_phase = P_FIRST;
        end else begin
          bytes_due   = hdr_len;
          key_sel     = 2'd0;
          parse_phase = P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        k = key_word[8*key_sel +: 8];
        key_sel   = key_sel + 2'd1;
        bytes_due = bytes_due - 7'd1;
        produced  = 1'b1;
        w = frame_word(b ^ k, bytes_due == 7'd0, wsfu_pkg::ST_PAYLOAD);
        if (bytes_due == 7'd0) parse_phase = P_FIRST;
      end
      default: begin
        hdr_fin     = b[7];
        hdr_rsv     = b[6:4];
        hdr_opcode  = b[3:0];
        parse_phase = P_SECOND;
      end
    endcase
  endtask

  // Check outputs, then fold accepted bytes into the parser copy.
  always @(posedge clk) begin
    wsfu_pkg::result_t seen;
    wsfu_pkg::result_t want;
    wsfu_pkg::result_t w;
    frame_row_t        row;
    bit                produced;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen = '{payload_byte, opcode, final_flag, reserved_bits, mask_present,
                 frame_length, last_of_frame, wsfu_pkg::status_t'(status)};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected word %h", $realtime, seen);
        end else begin
          want = expected_words.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: word mismatch", $realtime);
              $display("  data exp %h got %h  op exp %h got %h  fin exp %b got %b",
                       want.payload_byte, seen.payload_byte, want.opcode, seen.opcode,
                       want.final_flag, seen.final_flag);
              $display("  rsv exp %h got %h  mask exp %b got %b  len exp %0d got %0d",
                       want.reserved_bits, seen.reserved_bits, want.mask_present,
                       seen.mask_present, want.frame_length, seen.frame_length);
              $display("  last exp %b got %b  status exp %0d got %0d",
                       want.last_of_frame, seen.last_of_frame, want.status, seen.status);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        row = offered_rows.pop_front();
        unmask_byte(frame_byte, produced, w);
        if (produced) expected_words.push_back(row.fixed ? row.word : w);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else if (!rst) begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one word and hold it until taken; called at a falling edge.
  task automatic send_byte(input logic [7:0] b, input bit fixed = 1'b0,
                           input wsfu_pkg::result_t word = NO_WORD);
    if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    frame_byte <= b;
    offered_rows.push_back('{b, fixed, word});
    items_offered++;
    if ($urandom_range(0, 59) == 0) gaps_on = !gaps_on;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_frame();
    int         pick;
    int         len;
    int         cut;
    logic [7:0] hdr;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // raw noise, may leave the parser mid-frame
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else begin
      hdr  = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 6)       len = $urandom_range(126, 127);
      else if (pick < 14) len = 0;
      else if (pick < 18) len = $urandom_range(60, 125);
      else                len = $urandom_range(1, 12);
      send_byte(hdr);
      send_byte({($urandom_range(0, 9) != 0), 7'(len)});
      if (len < 126) begin
        repeat (4) send_byte(8'($urandom));
        cut = len;
        // truncated frame: the next header lands inside the payload
        if (len > 1 && $urandom_range(0, 19) == 0) cut = $urandom_range(1, len - 1);
        repeat (cut) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!held_off && items_offered >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (!quiet && stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
      if ($urandom_range(0, 99) == 0) stalls_on = !stalls_on;
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    frame_byte = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (frame_rows[i]) send_byte(frame_rows[i].stim, frame_rows[i].fixed,
                                      frame_rows[i].word);
    while (items_offered < RANDOM_ITEMS) begin
      if (items_offered >= QUIET_AFTER) quiet = 1'b1;
      send_random_frame();
    end
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    // drain: catch any stray word behind the last expected one
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
